// File: design/olr_pkg.sv
// shared types, constants, font table and lookup functions for the text line renderer
package olr_pkg;

  // line geometry
  localparam int LINE_COLUMNS = 128;
  localparam int GLYPH_WIDTH  = 5;
  localparam int CELL_WIDTH   = GLYPH_WIDTH + 1;
  localparam int CHAR_LIMIT   = LINE_COLUMNS - 2;
  localparam int COL_W        = 7;
  localparam int GLYPH_COUNT  = 35;
  localparam int GLYPH_IDX_W  = $clog2(GLYPH_COUNT);
  localparam int STEP_W       = $clog2(CELL_WIDTH);

  // descriptor queue, power-of-two depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // controller bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_CHAR  = 2'd1;
  localparam logic [1:0] ACT_PAD   = 2'd2;

  // work kinds in the descriptor queue
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_PAD   = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] page;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic [7:0] repeat_count;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [2:0]             page;
    logic [GLYPH_IDX_W-1:0] glyph;
    logic [7:0]             rep;
  } desc_t;

  // one glyph per entry, first column in the top byte
  localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
    40'h00_00_00_00_00, // blank
    40'h08_08_08_08_08, // dash
    40'h00_60_60_00_00, // period
    40'h00_36_36_00_00, // colon
    40'h3E_51_49_45_3E, // 0
    40'h00_42_7F_40_00,
    40'h42_61_51_49_46,
    40'h21_41_45_4B_31,
    40'h18_14_12_7F_10,
    40'h27_45_45_45_39,
    40'h3C_4A_49_49_30,
    40'h01_71_09_05_03,
    40'h36_49_49_49_36,
    40'h06_49_49_29_1E, // 9
    40'h7E_11_11_11_7E, // A
    40'h7F_49_49_49_36, // B
    40'h7F_41_41_22_1C, // D
    40'h7F_49_49_49_41, // E
    40'h7F_09_09_09_01, // F
    40'h3E_41_49_49_7A, // G
    40'h00_41_7F_41_00, // I
    40'h7F_08_14_22_41, // K
    40'h7F_40_40_40_40, // L
    40'h7F_02_0C_02_7F, // M
    40'h7F_04_08_10_7F, // N
    40'h3E_41_41_41_3E, // O
    40'h7F_09_09_09_06, // P
    40'h3E_41_51_21_5E, // Q
    40'h7F_09_19_29_46, // R
    40'h46_49_49_49_31, // S
    40'h01_01_7F_01_01, // T
    40'h3F_40_40_40_3F, // U
    40'h1F_20_40_20_1F, // V
    40'h3F_40_38_40_3F, // W
    40'h07_08_70_08_07  // Y
  };

  // fold lower case, then map the code to a font entry; unknown codes are blank
  function automatic logic [GLYPH_IDX_W-1:0] font_index(input logic [7:0] code);
    logic [7:0] folded;
    logic [GLYPH_IDX_W-1:0] idx;
    folded = code;
    if (code >= 8'h61 && code <= 8'h7A) begin
      folded = code - 8'h20;
    end
    if (folded >= 8'h30 && folded <= 8'h39) begin
      idx = GLYPH_IDX_W'(folded[3:0]) + GLYPH_IDX_W'(4);
    end else begin
      unique case (folded)
        8'h2D:   idx = GLYPH_IDX_W'(1);
        8'h2E:   idx = GLYPH_IDX_W'(2);
        8'h3A:   idx = GLYPH_IDX_W'(3);
        8'h41:   idx = GLYPH_IDX_W'(14);
        8'h42:   idx = GLYPH_IDX_W'(15);
        8'h44:   idx = GLYPH_IDX_W'(16);
        8'h45:   idx = GLYPH_IDX_W'(17);
        8'h46:   idx = GLYPH_IDX_W'(18);
        8'h47:   idx = GLYPH_IDX_W'(19);
        8'h49:   idx = GLYPH_IDX_W'(20);
        8'h4B:   idx = GLYPH_IDX_W'(21);
        8'h4C:   idx = GLYPH_IDX_W'(22);
        8'h4D:   idx = GLYPH_IDX_W'(23);
        8'h4E:   idx = GLYPH_IDX_W'(24);
        8'h4F:   idx = GLYPH_IDX_W'(25);
        8'h50:   idx = GLYPH_IDX_W'(26);
        8'h51:   idx = GLYPH_IDX_W'(27);
        8'h52:   idx = GLYPH_IDX_W'(28);
        8'h53:   idx = GLYPH_IDX_W'(29);
        8'h54:   idx = GLYPH_IDX_W'(30);
        8'h55:   idx = GLYPH_IDX_W'(31);
        8'h56:   idx = GLYPH_IDX_W'(32);
        8'h57:   idx = GLYPH_IDX_W'(33);
        8'h59:   idx = GLYPH_IDX_W'(34);
        default: idx = '0;
      endcase
    end
    return idx;
  endfunction

  // column byte of a glyph cell; the spacer column reads as zero
  function automatic logic [7:0] glyph_byte(input logic [39:0] row,
                                            input logic [STEP_W-1:0] step);
    logic [7:0] b;
    unique case (step)
      STEP_W'(0): b = row[39:32];
      STEP_W'(1): b = row[31:24];
      STEP_W'(2): b = row[23:16];
      STEP_W'(3): b = row[15:8];
      STEP_W'(4): b = row[7:0];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: design/olr_front.sv
// front end: accepts items, tracks the line column and queues work descriptors
module olr_front import olr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  in_item_t       in_data,
  input  logic           q_full,
  output logic           push,
  output desc_t          push_desc,
  output logic [COL_W-1:0] column
);

  logic [COL_W-1:0] column_next;
  logic             accept;
  logic             emits;
  logic [7:0]       col_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign col_ext  = {1'b0, column};
  assign push     = accept && emits;

  always_comb begin
    emits            = 1'b0;
    column_next      = column;
    push_desc.kind   = KIND_START;
    push_desc.page   = in_data.page;
    push_desc.glyph  = font_index(in_data.char_code);
    push_desc.rep    = 8'd1;
    unique case (in_data.action)
      ACT_START: begin
        emits       = 1'b1;
        column_next = '0;
      end
      ACT_CHAR: begin
        push_desc.kind = KIND_CHAR;
        if (col_ext < 8'(CHAR_LIMIT)) begin
          emits       = 1'b1;
          column_next = column + COL_W'(CELL_WIDTH);
        end
      end
      ACT_PAD: begin
        push_desc.kind = KIND_PAD;
        push_desc.rep  = 8'(LINE_COLUMNS) - col_ext;
        if (9'(col_ext) < 9'(LINE_COLUMNS)) begin
          emits = 1'b1;
        end
      end
      default: begin
        emits = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
    end else if (accept) begin
      column <= column_next;
    end
  end

endmodule

// File: design/olr_queue.sv
// small descriptor fifo between front and back
module olr_queue import olr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head,
  output logic  empty,
  output logic  full
);

  desc_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/olr_back.sv
// back end: expands each descriptor into controller bytes, one per cycle unless the output stalls
module olr_back import olr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  desc_t     head,
  input  logic      q_empty,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] last_step;
  logic              advance;
  logic              issue;
  logic              last_now;
  out_item_t         res;

  assign advance  = !out_valid || out_ready;
  assign issue    = advance && !q_empty;
  assign last_now = (step == last_step);
  assign pop      = issue && last_now;

  always_comb begin
    res.repeat_count = 8'd1;
    res.last         = last_now;
    unique case (head.kind)
      KIND_START: begin
        last_step   = STEP_W'(2);
        res.is_data = 1'b0;
        unique case (step)
          STEP_W'(0): res.out_byte = CMD_PAGE_BASE + 8'(head.page);
          STEP_W'(1): res.out_byte = CMD_COL_LOW;
          default:    res.out_byte = CMD_COL_HIGH;
        endcase
      end
      KIND_CHAR: begin
        last_step    = STEP_W'(CELL_WIDTH - 1);
        res.is_data  = 1'b1;
        res.out_byte = glyph_byte(FONT_ROM[head.glyph], step);
      end
      default: begin
        last_step        = '0;
        res.is_data      = 1'b1;
        res.out_byte     = 8'h00;
        res.repeat_count = head.rep;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (advance) begin
        out_valid <= !q_empty;
      end
      if (issue) begin
        step <= last_now ? '0 : step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_data <= res;
    end
  end

endmodule

// File: design/oled_text_line_renderer.sv
// top level of the text line renderer: front end, descriptor queue, byte generator
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------
//   in      | input     | in_valid / in_ready   | in_data  (action, page, char_code)
//   out     | output    | out_valid / out_ready | out_data (out_byte, is_data,
//           |           |                       |           repeat_count, last)
//
// rate: one result per cycle from the back end unless out_ready stalls it; a character gives
//   six results, a start line three and an end line one; items that emit nothing queue nothing
// the byte generator in the back end is the bottleneck; the front runs ahead by up to
//   two queued descriptors and keeps accepting while a result waits in the output register
// reset: synchronous, clears the column, the queue pointers, the step counter and out_valid
// stalls: out_ready low while out_valid is high freezes the output register and the back end;
//   in_ready drops only when the queue is full
module oled_text_line_renderer import olr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // front to queue
  logic             push;
  desc_t            push_desc;
  logic [COL_W-1:0] column;

  // queue to back
  desc_t head;
  logic  q_empty;
  logic  q_full;
  logic  pop;

  // classify items, keep the column, drop characters past the line end
  olr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .column    (column)
  );

  // decouples item intake from byte generation
  olr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // walks each descriptor one byte per cycle into the output register unless out_ready stalls it
  olr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("descriptor pushed into a full queue");

  // queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && q_empty))
    else $error("descriptor popped from an empty queue");

  // a start line item rewinds the column
  a_start_rewinds: assert property (@(posedge clk) disable iff (rst)
      in_valid && in_ready && in_data.action == ACT_START |=> column == '0)
    else $error("column not cleared after start line");

  // command bytes are always sent once
  a_cmd_single: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_data.is_data |-> out_data.repeat_count == 8'd1)
    else $error("command byte with repeat count other than one");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// testbench for the text line renderer: directed and random text lines checked by a scoreboard
module tb_top;
  import olr_pkg::*;

  // action code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // cycles without any handshake before the run is declared hung
  localparam int IDLE_LIMIT = 4000;
  // random items per idle phase
  localparam int PHASE_ITEMS = 54;

  // predicts the byte stream of each accepted item and checks results in order
  class line_scoreboard;
    out_item_t  byte_q[$];
    logic [6:0] column;
    int         errors;
    int         n_items;
    int         n_results;
    int         n_dropped;
    int         n_pads;

    function new();
      column    = '0;
      errors    = 0;
      n_items   = 0;
      n_results = 0;
      n_dropped = 0;
      n_pads    = 0;
    endfunction

    // 5x7 glyph, first column in the top byte; lower case folds, unknown codes are blank
    function logic [39:0] glyph_of(logic [7:0] code);
      logic [7:0]  c;
      logic [39:0] g;
      c = code;
      if (c >= "a" && c <= "z") c = c - 8'h20;
      case (c)
        "-": g = 40'h08_08_08_08_08;
        ".": g = 40'h00_60_60_00_00;
        ":": g = 40'h00_36_36_00_00;
        "0": g = 40'h3E_51_49_45_3E;
        "1": g = 40'h00_42_7F_40_00;
        "2": g = 40'h42_61_51_49_46;
        "3": g = 40'h21_41_45_4B_31;
        "4": g = 40'h18_14_12_7F_10;
        "5": g = 40'h27_45_45_45_39;
        "6": g = 40'h3C_4A_49_49_30;
        "7": g = 40'h01_71_09_05_03;
        "8": g = 40'h36_49_49_49_36;
        "9": g = 40'h06_49_49_29_1E;
        "A": g = 40'h7E_11_11_11_7E;
        "B": g = 40'h7F_49_49_49_36;
        "D": g = 40'h7F_41_41_22_1C;
        "E": g = 40'h7F_49_49_49_41;
        "F": g = 40'h7F_09_09_09_01;
        "G": g = 40'h3E_41_49_49_7A;
        "I": g = 40'h00_41_7F_41_00;
        "K": g = 40'h7F_08_14_22_41;
        "L": g = 40'h7F_40_40_40_40;
        "M": g = 40'h7F_02_0C_02_7F;
        "N": g = 40'h7F_04_08_10_7F;
        "O": g = 40'h3E_41_41_41_3E;
        "P": g = 40'h7F_09_09_09_06;
        "Q": g = 40'h3E_41_51_21_5E;
        "R": g = 40'h7F_09_19_29_46;
        "S": g = 40'h46_49_49_49_31;
        "T": g = 40'h01_01_7F_01_01;
        "U": g = 40'h3F_40_40_40_3F;
        "V": g = 40'h1F_20_40_20_1F;
        "W": g = 40'h3F_40_38_40_3F;
        "Y": g = 40'h07_08_70_08_07;
        default: g = '0;
      endcase
      return g;
    endfunction

    function void push(logic [7:0] b, logic data, logic [7:0] rep, logic fin);
      out_item_t e;
      e.out_byte     = b;
      e.is_data      = data;
      e.repeat_count = rep;
      e.last         = fin;
      byte_q.push_back(e);
    endfunction

    function void note_input(in_item_t it);
      logic [39:0] g;
      int          i;
      n_items++;
      case (it.action)
        ACT_START: begin
          push(CMD_PAGE_BASE + 8'(it.page), 1'b0, 8'd1, 1'b0);
          push(CMD_COL_LOW, 1'b0, 8'd1, 1'b0);
          push(CMD_COL_HIGH, 1'b0, 8'd1, 1'b1);
          column = '0;
        end
        ACT_CHAR: begin
          if (column < CHAR_LIMIT) begin
            g = glyph_of(it.char_code);
            for (i = 0; i < GLYPH_WIDTH; i++) push(g[39 - 8*i -: 8], 1'b1, 8'd1, 1'b0);
            push(8'h00, 1'b1, 8'd1, 1'b1);
            column = column + 7'(CELL_WIDTH);
          end else begin
            n_dropped++;
          end
        end
        ACT_PAD: begin
          // the 7-bit column is always below the line width, so padding always comes out
          push(8'h00, 1'b1, 8'(LINE_COLUMNS - int'(column)), 1'b1);
          n_pads++;
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (byte_q.size() == 0) begin
        $error("unexpected result: out_byte %02h is_data %0d repeat_count %0d last %0d",
               got.out_byte, got.is_data, got.repeat_count, got.last);
        errors++;
        return;
      end
      want = byte_q.pop_front();
      n_results++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.is_data !== want.is_data) begin
        $error("is_data: expected %0d, got %0d", want.is_data, got.is_data);
        errors++;
      end
      if (got.repeat_count !== want.repeat_count) begin
        $error("repeat_count: expected %0d, got %0d", want.repeat_count, got.repeat_count);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  line_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent_count = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  oled_text_line_renderer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  function automatic in_item_t mk(logic [1:0] act, logic [2:0] pg, logic [7:0] code);
    in_item_t it;
    it.action    = act;
    it.page      = pg;
    it.char_code = code;
    return it;
  endfunction

  // mostly printable text, the rest anywhere in the 8-bit range
  function automatic logic [7:0] rand_code();
    if ($urandom_range(99) < 60) return 8'($urandom_range(8'h7A, 8'h20));
    return 8'($urandom_range(255, 0));
  endfunction

  // present one item, idling first at random; returns right after the accepting edge
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // well-formed line: start, a run of characters, end; long runs reach the line-full case
  task automatic random_line();
    int n;
    send_item(mk(ACT_START, 3'($urandom), 8'($urandom)));
    n = ($urandom_range(99) < 30) ? $urandom_range(24, 18) : $urandom_range(8, 0);
    repeat (n) send_item(mk(ACT_CHAR, 3'($urandom), rand_code()));
    send_item(mk(ACT_PAD, 3'($urandom), 8'($urandom)));
  endtask

  // monitor both channels, drive the receiver side, and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= ($urandom_range(99) >= stall_pct);
      // count cycles with no item moving on either side
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("oled_text_line_renderer verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int phase;
    int phase_start;
    int idle_mix[4][2];
    // sender idle / receiver stall percentages per phase
    idle_mix = '{'{0, 0}, '{80, 0}, '{0, 80}, '{38, 38}};
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: case folding, digits, punctuation, unknown and high codes,
    // both page extremes, padding of an empty line, the unused action
    send_item(mk(ACT_START, 3'd0, 8'h00));
    send_item(mk(ACT_CHAR, 3'd0, "a"));
    send_item(mk(ACT_CHAR, 3'd0, "z"));
    send_item(mk(ACT_CHAR, 3'd0, "0"));
    send_item(mk(ACT_CHAR, 3'd0, "9"));
    send_item(mk(ACT_CHAR, 3'd0, "-"));
    send_item(mk(ACT_CHAR, 3'd0, "."));
    send_item(mk(ACT_CHAR, 3'd0, ":"));
    send_item(mk(ACT_CHAR, 3'd0, "Y"));
    send_item(mk(ACT_CHAR, 3'd0, 8'h00));
    send_item(mk(ACT_CHAR, 3'd0, 8'h80));
    send_item(mk(ACT_CHAR, 3'd0, 8'hFF));
    send_item(mk(ACT_CHAR, 3'd0, 8'h7F));
    send_item(mk(ACT_PAD, 3'd0, 8'h00));
    send_item(mk(ACT_UNUSED, 3'd7, 8'hFF));
    send_item(mk(ACT_START, 3'd7, 8'hFF));
    send_item(mk(ACT_CHAR, 3'd7, "m"));
    send_item(mk(ACT_PAD, 3'd7, 8'hFF));
    send_item(mk(ACT_PAD, 3'd0, 8'h00));
    send_item(mk(ACT_CHAR, 3'd0, "W"));
    send_item(mk(ACT_START, 3'd5, 8'h00));
    send_item(mk(ACT_PAD, 3'd2, 8'h41));

    // random lines with some stray and unused items mixed in, under each idle mix
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_mix[phase][0];
      stall_pct     = idle_mix[phase][1];
      phase_start   = sent_count;
      while (sent_count - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 15) begin
          send_item(mk(2'($urandom), 3'($urandom), 8'($urandom)));
        end else begin
          random_line();
        end
      end
    end
    in_valid <= 1'b0;

    // drain, then give the block time to show any stray result
    while (sb.byte_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d input items and %0d result bytes, %0d padded line ends,",
             sb.n_items, sb.n_results, sb.n_pads);
    $display("%0d characters dropped on full lines, under four sender/receiver idle mixes",
             sb.n_dropped);
    if (sb.errors == 0 && sb.byte_q.size() == 0) begin
      $display("oled_text_line_renderer verification clean");
    end else begin
      $display("oled_text_line_renderer verification failed");
    end
    $finish;
  end

endmodule
